// ===== hw/rtl/stc_pkg.sv =====
// Shared types and constants for the set-associative cache tag controller.
// No dependencies; used by every module of the block.
`default_nettype none

package stc_pkg;

    localparam int MAX_SETS_DEF   = 256;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_BITS_DEF  = 48;
    localparam int COUNT_BITS_DEF = 32;

    localparam int CLOCK_W  = 48;
    localparam int LFSR_W   = 16;
    localparam int WCNT_W   = 6;
    localparam int OUT_W    = 16;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

    localparam logic [2:0] REG_OFFSET_SHIFT  = 3'd0;
    localparam logic [2:0] REG_INDEX_WIDTH   = 3'd1;
    localparam logic [2:0] REG_WAYS_IN_USE   = 3'd2;
    localparam logic [2:0] REG_REPLACE_MODE  = 3'd3;
    localparam logic [2:0] REG_WT_MODE       = 3'd4;

    localparam logic [1:0] MODE_LRU  = 2'd0;
    localparam logic [1:0] MODE_FIFO = 2'd1;
    localparam logic [1:0] MODE_LFU  = 2'd2;
    localparam logic [1:0] MODE_RAND = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_DECIDE,
        ST_MOD,
        ST_UPDATE
    } stc_state_t;

    typedef struct packed {
        logic [4:0] offset_shift;
        logic [3:0] index_width;
        logic [3:0] ways_in_use;
        logic [1:0] replace_mode;
        logic       wt_mode;
    } stc_cfg_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic rd;
        logic scan;
        logic mod_start;
        logic mod_step;
        logic update;
    } stc_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic need_rand;
        logic mod_done;
        logic out_free;
    } stc_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stc_cfg.sv =====
// APB register file for the cache tag controller configuration.
// Depends on stc_pkg.
`default_nettype none

module stc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [stc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [stc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [stc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output stc_pkg::stc_cfg_t                  cfg
);
    import stc_pkg::*;

    stc_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_shift  <= 5'd6;
            cfg_reg.index_width   <= 4'd8;
            cfg_reg.ways_in_use   <= 4'd8;
            cfg_reg.replace_mode  <= MODE_LRU;
            cfg_reg.wt_mode       <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OFFSET_SHIFT:  cfg_reg.offset_shift  <= pwdata[4:0];
                REG_INDEX_WIDTH:   cfg_reg.index_width   <= pwdata[3:0];
                REG_WAYS_IN_USE:   cfg_reg.ways_in_use   <= pwdata[3:0];
                REG_REPLACE_MODE:  cfg_reg.replace_mode  <= pwdata[1:0];
                REG_WT_MODE:       cfg_reg.wt_mode       <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_OFFSET_SHIFT:  prdata[4:0] = cfg_reg.offset_shift;
            REG_INDEX_WIDTH:   prdata[3:0] = cfg_reg.index_width;
            REG_WAYS_IN_USE:   prdata[3:0] = cfg_reg.ways_in_use;
            REG_REPLACE_MODE:  prdata[1:0] = cfg_reg.replace_mode;
            REG_WT_MODE:       prdata[0]   = cfg_reg.wt_mode;
            default:           prdata      = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stc_ctrl.sv =====
// Sequencing state machine: clearing pass, set read, way scan, random modulo, update.
// Depends on stc_pkg.
`default_nettype none

module stc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  stc_pkg::stc_status_t      status,
    output stc_pkg::stc_cmd_t         cmd
);
    import stc_pkg::*;

    stc_state_t state_reg;
    stc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = ST_READ;
            ST_READ:   state_next = ST_SCAN;
            ST_SCAN:   if (status.scan_last) state_next = ST_DECIDE;
            ST_DECIDE: state_next = status.need_rand ? ST_MOD : ST_UPDATE;
            ST_MOD:    if (status.mod_done) state_next = ST_UPDATE;
            ST_UPDATE: if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear_wr = 1'b1;
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_READ:   cmd.rd = 1'b1;
            ST_SCAN:   cmd.scan = 1'b1;
            ST_DECIDE: cmd.mod_start = status.need_rand;
            ST_MOD:    cmd.mod_step = 1'b1;
            ST_UPDATE: cmd.update = status.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stc_dp.sv =====
// Datapath: set memory, address split, way scan, victim choice, line update, result register.
// Depends on stc_pkg; driven by stc_ctrl.
`default_nettype none

module stc_dp #(
    parameter int MAX_SETS   = stc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = stc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS  = stc_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = stc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  stc_pkg::stc_cmd_t                cmd,
    output stc_pkg::stc_status_t             status,
    input  stc_pkg::stc_cfg_t                cfg,
    input  wire logic [ADDR_BITS-1:0]        address,
    input  wire logic                        op,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [stc_pkg::OUT_W-1:0]   m_tdata
);
    import stc_pkg::*;

    localparam int LOG_SETS = $clog2(MAX_SETS + 1) - 1;
    localparam int IDXW     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAYW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int KEYW     = (CLOCK_W > COUNT_BITS) ? CLOCK_W : COUNT_BITS;
    localparam int LINEW    = 2 + ADDR_BITS + 2 * CLOCK_W + COUNT_BITS;
    localparam int ROWW     = MAX_WAYS * LINEW;
    localparam int TAG_LO   = 2;
    localparam int LAST_LO  = TAG_LO + ADDR_BITS;
    localparam int FILL_LO  = LAST_LO + CLOCK_W;
    localparam int CNT_LO   = FILL_LO + CLOCK_W;
    localparam int RW       = WCNT_W + 1;

    logic [ROWW-1:0] mem [MAX_SETS];

    logic [ROWW-1:0]       row_reg;
    logic [IDXW-1:0]       set_reg;
    logic [ADDR_BITS-1:0]  tag_reg;
    logic                  op_reg;
    logic [CLOCK_W-1:0]    clock_reg;
    logic [LFSR_W-1:0]     lfsr_reg;
    logic [IDXW-1:0]       clr_cnt_reg;
    logic [WAYW-1:0]       way_cnt_reg;
    logic                  hit_found_reg;
    logic [WAYW-1:0]       hit_way_reg;
    logic                  inv_found_reg;
    logic [WAYW-1:0]       inv_way_reg;
    logic [KEYW-1:0]       best_key_reg;
    logic [WAYW-1:0]       best_way_reg;
    logic [RW-1:0]         rem_reg;
    logic [LFSR_W-1:0]     div_reg;
    logic [3:0]            mod_cnt_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    logic [4:0]              iw_eff;
    logic [WCNT_W-1:0]       ways_raw;
    logic [WCNT_W-1:0]       ways_eff;
    logic [16:0]             set_mask;
    logic [ADDR_BITS-1:0]    addr_shifted;
    logic [ADDR_BITS+16:0]   addr_shifted_ext;
    logic [16:0]             set_wide;
    logic [ADDR_BITS-1:0]    tag_next;
    logic [LINEW-1:0]        scan_line;
    logic [KEYW-1:0]         scan_key;
    logic [LFSR_W-1:0]       lfsr_next;
    logic [RW-1:0]           rem_shift;
    logic [RW-1:0]           ways_ext;
    logic [WAYW-1:0]         victim;
    logic [LINEW-1:0]        old_line;
    logic [LINEW-1:0]        new_line;
    logic [ROWW-1:0]         new_row;
    logic [COUNT_BITS-1:0]   old_count;
    logic                    res_evicted;
    logic                    res_writeback;
    logic [WAYW+2:0]         victim_ext;
    logic [IDXW+7:0]         set_ext;
    logic                    out_free;

    // effective configuration
    always_comb
    begin
        iw_eff = ({1'b0, cfg.index_width} > 5'(LOG_SETS)) ? 5'(LOG_SETS)
                                                          : {1'b0, cfg.index_width};
        ways_raw = {2'b00, cfg.ways_in_use};
        if (ways_raw == '0)
            ways_eff = WCNT_W'(1);
        else if (ways_raw > WCNT_W'(MAX_WAYS))
            ways_eff = WCNT_W'(MAX_WAYS);
        else
            ways_eff = ways_raw;
    end

    assign set_mask         = (17'd1 << iw_eff) - 17'd1;
    assign addr_shifted     = address >> cfg.offset_shift;
    assign addr_shifted_ext = {17'b0, addr_shifted};
    assign set_wide         = addr_shifted_ext[16:0] & set_mask;
    assign tag_next         = address >> (6'(cfg.offset_shift) + 6'(iw_eff));

    assign scan_line = row_reg[way_cnt_reg * LINEW +: LINEW];

    always_comb
    begin
        case (cfg.replace_mode)
            MODE_LRU:  scan_key = KEYW'(scan_line[LAST_LO +: CLOCK_W]);
            MODE_FIFO: scan_key = KEYW'(scan_line[FILL_LO +: CLOCK_W]);
            MODE_LFU:  scan_key = KEYW'(scan_line[CNT_LO +: COUNT_BITS]);
            default:   scan_key = '0;
        endcase
    end

    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign ways_ext  = {1'b0, ways_eff};
    assign rem_shift = {rem_reg[RW-2:0], div_reg[LFSR_W-1]};

    always_comb
    begin
        if (hit_found_reg)
            victim = hit_way_reg;
        else if (inv_found_reg)
            victim = inv_way_reg;
        else if (cfg.replace_mode == MODE_RAND)
            victim = rem_reg[WAYW-1:0];
        else
            victim = best_way_reg;
    end

    assign old_line  = row_reg[victim * LINEW +: LINEW];
    assign old_count = old_line[CNT_LO +: COUNT_BITS];

    always_comb
    begin
        new_line      = old_line;
        res_evicted   = 1'b0;
        res_writeback = 1'b0;
        if (hit_found_reg)
        begin
            new_line[1] = old_line[1] | op_reg;
            new_line[LAST_LO +: CLOCK_W] = clock_reg;
            if (old_count != '1)
                new_line[CNT_LO +: COUNT_BITS] = old_count + COUNT_BITS'(1);
            res_writeback = op_reg & cfg.wt_mode;
        end
        else
        begin
            res_evicted   = old_line[0];
            res_writeback = old_line[0] & old_line[1];
            new_line = {COUNT_BITS'(1), clock_reg, clock_reg, tag_reg, op_reg, 1'b1};
        end
        new_row = row_reg;
        new_row[victim * LINEW +: LINEW] = new_line;
    end

    assign victim_ext = (WAYW + 3)'(victim);
    assign set_ext    = (IDXW + 8)'(set_reg);

    // set memory: one row per set, every way of the set side by side
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
            mem[clr_cnt_reg] <= '0;
        else if (cmd.update)
            mem[set_reg] <= new_row;
        if (cmd.rd)
            row_reg <= mem[set_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            clock_reg     <= '0;
            lfsr_reg      <= LFSR_SEED;
            way_cnt_reg   <= '0;
            hit_found_reg <= 1'b0;
            inv_found_reg <= 1'b0;
            mod_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
                clr_cnt_reg <= clr_cnt_reg + IDXW'(1);
            if (cmd.accept)
                clock_reg <= clock_reg + CLOCK_W'(1);
            if (cmd.rd)
            begin
                way_cnt_reg   <= '0;
                hit_found_reg <= 1'b0;
                inv_found_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                way_cnt_reg <= way_cnt_reg + WAYW'(1);
                if (!hit_found_reg && scan_line[0] && scan_line[TAG_LO +: ADDR_BITS] == tag_reg)
                    hit_found_reg <= 1'b1;
                if (!inv_found_reg && !scan_line[0])
                    inv_found_reg <= 1'b1;
            end
            if (cmd.mod_start)
            begin
                lfsr_reg    <= lfsr_next;
                mod_cnt_reg <= '0;
            end
            if (cmd.mod_step)
                mod_cnt_reg <= mod_cnt_reg + 4'd1;
            if (cmd.update)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_reg <= set_wide[IDXW-1:0];
            tag_reg <= tag_next;
            op_reg  <= op;
        end
        if (cmd.scan)
        begin
            if (!hit_found_reg)
                hit_way_reg <= way_cnt_reg;
            if (!inv_found_reg)
                inv_way_reg <= way_cnt_reg;
            if (way_cnt_reg == '0 || scan_key < best_key_reg)
            begin
                best_key_reg <= scan_key;
                best_way_reg <= way_cnt_reg;
            end
        end
        if (cmd.mod_start)
        begin
            div_reg <= lfsr_next;
            rem_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            div_reg <= div_reg << 1;
            rem_reg <= (rem_shift >= ways_ext) ? rem_shift - ways_ext : rem_shift;
        end
        if (cmd.update)
            m_tdata_reg <= {2'b00, set_ext[7:0], victim_ext[2:0],
                            res_writeback, res_evicted, hit_found_reg};
    end

    assign out_free = !m_tvalid_reg || m_tready;

    assign status.clear_last = (clr_cnt_reg == IDXW'(MAX_SETS - 1));
    assign status.scan_last  = ((WCNT_W'(way_cnt_reg) + WCNT_W'(1)) == ways_eff);
    assign status.need_rand  = !hit_found_reg && !inv_found_reg
                               && (cfg.replace_mode == MODE_RAND);
    assign status.mod_done   = (mod_cnt_reg == 4'd15);
    assign status.out_free   = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_tag_controller.sv =====
// Cache tag and replacement engine, top level.
// Access beats enter on s_*: s_tdata holds address in the low ADDR_BITS bits and op
// (0 read, 1 write) above it. One result beat leaves on m_* per access: m_tdata holds
// hit, evicted, writeback, way[2:0], set_number[7:0] from bit 0 up.
// Configuration is written over APB at 4*i: offset_shift, index_width, ways_in_use,
// replace_mode, write mode. Write only while the engine is idle.
// One access at a time. An access reads its set row, scans one way per cycle, then
// writes the row back and loads the result; when a random victim is needed, a modulo
// step comes before the write-back (remainder taken one bit per cycle). s_tready rises
// again in the cycle after the result is loaded.
// After reset the set memory is cleared one row per cycle, all MAX_SETS rows, with
// s_tready low; configuration writes are taken meanwhile.
// The result is held in an output register; the next access may be accepted while it
// waits, but its own result waits until m_tready frees the register.
// Depends on stc_pkg, stc_cfg, stc_ctrl, stc_dp.
`default_nettype none

module set_assoc_cache_tag_controller #(
    parameter int MAX_SETS   = stc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = stc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS  = stc_pkg::ADDR_BITS_DEF,
    parameter int COUNT_BITS = stc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // address, op
    input  wire logic [((ADDR_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // hit, evicted, writeback, way[2:0], set_number[7:0]
    output logic      [stc_pkg::OUT_W-1:0]             m_tdata,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [stc_pkg::PADDR_W-1:0]           paddr,
    input  wire logic [stc_pkg::PDATA_W-1:0]           pwdata,
    output logic      [stc_pkg::PDATA_W-1:0]           prdata,
    output logic                                       pready
);
    import stc_pkg::*;

    stc_cfg_t    cfg;
    stc_cmd_t    cmd;
    stc_status_t status;

    stc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stc_dp #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_BITS  (ADDR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .cfg      (cfg),
        .address  (s_tdata[ADDR_BITS-1:0]),
        .op       (s_tdata[ADDR_BITS]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/stc_checker.sv =====
// Port-level checks for the cache tag controller, bound to the top level.
// Depends on stc_pkg and set_assoc_cache_tag_controller.
`default_nettype none

module stc_checker #(
    parameter int ADDR_BITS = stc_pkg::ADDR_BITS_DEF
) (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  s_tvalid,
    input wire logic                                  s_tready,
    input wire logic [((ADDR_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [stc_pkg::OUT_W-1:0]             m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[1])
        else $error("hit reported with eviction");

    a_fill_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] && !m_tdata[1] |-> !m_tdata[2])
        else $error("writeback on a fill of an empty way");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second access taken while one is in flight");

endmodule

bind set_assoc_cache_tag_controller stc_checker #(.ADDR_BITS(ADDR_BITS)) u_stc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb_set_assoc_cache_tag_controller.sv =====
// Self-checking testbench for the set-associative cache tag controller.
// Holds its own predictor of tag match and victim choice; depends on stc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_set_assoc_cache_tag_controller;

    import stc_pkg::*;

    localparam int LINES = 256 * 8;

    typedef struct packed {
        logic        op;
        logic [47:0] addr;
    } access_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // address[47:0], op, zero fill
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // hit, evicted, writeback, way[2:0], set_number[7:0], zero fill
    logic [15:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic        pready;

    set_assoc_cache_tag_controller dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the tag store
    logic        sh_valid [LINES];
    logic        sh_dirty [LINES];
    logic [47:0] sh_tag [LINES];
    logic [47:0] sh_used [LINES];
    logic [47:0] sh_filled [LINES];
    logic [31:0] sh_uses [LINES];
    logic [47:0] sh_clock;
    logic [15:0] sh_lfsr;

    logic [4:0]  cf_offset;
    logic [3:0]  cf_index;
    logic [3:0]  cf_ways;
    logic [1:0]  cf_mode;
    logic        cf_wt;

    access_t     pending [$];
    logic [15:0] expected_results [$];
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          hits_seen = 0;
    int          evicts_seen = 0;
    int          phases_run = 0;
    bit          beat_taken = 0;
    bit          long_hold = 0;
    int          burst_left = 4;
    int          gap_left = 0;
    logic        next_valid;
    logic [7:0]  stall_pat = 8'hFF;
    int          stall_age = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [15:0] predict_access(logic [47:0] addr, logic wr);
        int          iw;
        int          nw;
        int          set_i;
        int          base;
        int          victim;
        logic [47:0] tag;
        logic [47:0] best;
        logic [47:0] val;
        logic        ev;
        logic        wb;
        iw = (cf_index > 8) ? 8 : cf_index;
        nw = (cf_ways == 0) ? 1 : ((cf_ways > 8) ? 8 : cf_ways);
        sh_clock = sh_clock + 1;
        set_i = int'((addr >> cf_offset) & ((48'd1 << iw) - 1));
        tag = addr >> (cf_offset + iw);
        base = set_i * 8;
        for (int w = 0; w < nw; w++)
        begin
            if (sh_valid[base + w] && sh_tag[base + w] == tag)
            begin
                sh_used[base + w] = sh_clock;
                if (sh_uses[base + w] != 32'hFFFF_FFFF)
                    sh_uses[base + w]++;
                wb = 1'b0;
                if (wr)
                begin
                    sh_dirty[base + w] = 1'b1;
                    wb = cf_wt;
                end
                return {2'b00, set_i[7:0], w[2:0], wb, 1'b0, 1'b1};
            end
        end
        victim = nw;
        for (int w = 0; w < nw; w++)
        begin
            if (!sh_valid[base + w] && victim == nw)
                victim = w;
        end
        if (victim == nw)
        begin
            if (cf_mode == MODE_RAND)
            begin
                sh_lfsr = sh_lfsr[0] ? ((sh_lfsr >> 1) ^ LFSR_TAPS) : (sh_lfsr >> 1);
                victim = int'(sh_lfsr) % nw;
            end
            else
            begin
                victim = 0;
                for (int w = 0; w < nw; w++)
                begin
                    case (cf_mode)
                        MODE_LRU:  val = sh_used[base + w];
                        MODE_FIFO: val = sh_filled[base + w];
                        default:   val = {16'd0, sh_uses[base + w]};
                    endcase
                    if (w == 0 || val < best)
                    begin
                        best = val;
                        victim = w;
                    end
                end
            end
        end
        ev = sh_valid[base + victim];
        wb = ev && sh_dirty[base + victim];
        sh_tag[base + victim] = tag;
        sh_valid[base + victim] = 1'b1;
        sh_dirty[base + victim] = wr;
        sh_used[base + victim] = sh_clock;
        sh_filled[base + victim] = sh_clock;
        sh_uses[base + victim] = 32'd1;
        return {2'b00, set_i[7:0], victim[2:0], wb, ev, 1'b0};
    endfunction

    task automatic report(string field, int got, int want);
        errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d", beats_out, field, got, want);
    endtask

    // input and output beats
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_results.push_back(predict_access(s_tdata[47:0], s_tdata[48]));
            beat_taken = 1;
            beats_in++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("result beat with nothing expected: %h", m_tdata);
            end
            else
            begin
                logic [15:0] want;
                want = expected_results.pop_front();
                if (m_tdata[0] !== want[0]) report("hit", m_tdata[0], want[0]);
                if (m_tdata[1] !== want[1]) report("evicted", m_tdata[1], want[1]);
                if (m_tdata[2] !== want[2]) report("writeback", m_tdata[2], want[2]);
                if (m_tdata[5:3] !== want[5:3]) report("way", m_tdata[5:3], want[5:3]);
                if (m_tdata[13:6] !== want[13:6])
                    report("set_number", m_tdata[13:6], want[13:6]);
                hits_seen += want[0];
                evicts_seen += want[1];
            end
            beats_out++;
        end
    end

    // sender: bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            next_valid = s_tvalid;
            if (s_tvalid && beat_taken)
                next_valid = 1'b0;
            beat_taken = 0;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() > 0)
                begin
                    s_tdata <= {7'd0, pending.pop_front()};
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // receiver: rotating stall pattern, reloaded now and then
    always @(negedge clk)
    begin
        if (stall_age == 0)
        begin
            stall_age = $urandom_range(20, 80);
            stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        end
        stall_age--;
        stall_pat = {stall_pat[6:0], stall_pat[7]};
        m_tready <= !long_hold && stall_pat[0];
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_OFFSET_SHIFT:  cf_offset = val[4:0];
            REG_INDEX_WIDTH:   cf_index = val[3:0];
            REG_WAYS_IN_USE:   cf_ways = val[3:0];
            REG_REPLACE_MODE:  cf_mode = val[1:0];
            default:           cf_wt = val[0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (pending.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(int off, int iw, int nw, logic [1:0] md, int wt);
        wait_idle();
        apb_write(REG_OFFSET_SHIFT, off);
        apb_write(REG_INDEX_WIDTH, iw);
        apb_write(REG_WAYS_IN_USE, nw);
        apb_write(REG_REPLACE_MODE, md);
        apb_write(REG_WT_MODE, wt);
        phases_run++;
    endtask

    // mostly a small pool of tags over a few sets, so hits and evictions are common
    task automatic random_phase(int count);
        logic [47:0] tags [12];
        logic [47:0] a;
        int          iw;
        iw = (cf_index > 8) ? 8 : cf_index;
        foreach (tags[i])
            tags[i] = 48'({$urandom, $urandom});
        for (int n = 0; n < count; n++)
        begin
            a = 48'({$urandom, $urandom});
            if ($urandom_range(0, 99) < 85)
            begin
                a = a & ((48'd1 << cf_offset) - 1);
                a = a | ((48'($urandom_range(0, 3)) & ((48'd1 << iw) - 1)) << cf_offset);
                a = a | (tags[$urandom_range(0, 11)] << (cf_offset + iw));
            end
            pending.push_back({1'($urandom), a});
        end
    endtask

    initial
    begin
        for (int i = 0; i < LINES; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
        end
        sh_clock = '0;
        sh_lfsr = LFSR_SEED;
        cf_offset = 5'd6;
        cf_index = 4'd8;
        cf_ways = 4'd8;
        cf_mode = MODE_LRU;
        cf_wt = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: address extremes, fill set 0 past its ways, write hits, dirty victims
        pending.push_back({1'b0, 48'h0});
        pending.push_back({1'b1, 48'hFFFF_FFFF_FFFF});
        pending.push_back({1'b0, 48'hFFFF_FFFF_FFFF});
        pending.push_back({1'b1, 48'h0});
        for (int t = 1; t <= 10; t++)
            pending.push_back({1'(t & 1), 48'(t) << 14});
        pending.push_back({1'b1, 48'd3 << 14});
        pending.push_back({1'b0, 48'h0});
        set_config(0, 0, 1, MODE_LRU, 1);
        pending.push_back({1'b1, 48'h5});
        pending.push_back({1'b1, 48'h5});
        pending.push_back({1'b0, 48'h6});
        pending.push_back({1'b0, 48'hA5A5_5A5A_F0F0});

        set_config(6, 8, 8, MODE_LRU, 0);   random_phase(180);
        set_config(0, 0, 8, MODE_FIFO, 1); random_phase(120);
        set_config(16, 3, 4, MODE_LFU, 0); random_phase(120);
        set_config(4, 2, 8, MODE_RAND, 1); random_phase(70);
        fork
            begin
                wait (beats_in > 1040);
                long_hold = 1;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
        join_none
        random_phase(100);
        set_config(31, 15, 15, MODE_RAND, 0); random_phase(120);
        set_config(5, 1, 0, MODE_LFU, 1);     random_phase(100);
        set_config(2, 8, 3, MODE_FIFO, 0);    random_phase(120);
        set_config(9, 4, 8, MODE_LRU, 1);     random_phase(120);
        set_config(1, 5, 7, MODE_RAND, 0);    random_phase(180);

        wait_idle();
        $display("%0d accesses over %0d settings of shift, sets, ways, policy and write mode",
                 beats_in, phases_run);
        $display("%0d hits and %0d evictions checked", hits_seen, evicts_seen);
        if (errors == 0)
            $display("set_assoc_cache_tag_controller regression: pass");
        else
            $display("set_assoc_cache_tag_controller regression: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("set_assoc_cache_tag_controller regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/stc_pkg.sv
hw/rtl/stc_cfg.sv
hw/rtl/stc_ctrl.sv
hw/rtl/stc_dp.sv
hw/rtl/set_assoc_cache_tag_controller.sv
hw/rtl/stc_checker.sv
tb/tb_set_assoc_cache_tag_controller.sv
